FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pata_pkg.sv
// ----------------------------------------------------------------------------
// pata_pkg
// Types, codes and sizes shared by the address aging table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pata_pkg;

  localparam int TRACK_COUNT_DEF = 8;
  localparam int ENTRIES_DEF     = 8;
  // slot and count fields are sized for the largest supported list
  localparam int MAX_ENTRIES     = 16;
  localparam int SLOT_W          = $clog2(MAX_ENTRIES);
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W          = 16;
  localparam int TMO_W           = 8;
  localparam int TRK_W           = 3;
  localparam int FUNC_W          = 3;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd10;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK        = 3'd0,
    FN_ADD         = 3'd1,
    FN_REMOVE      = 3'd2,
    FN_CLEAR_TRACK = 3'd3,
    FN_CLEAR_ALL   = 3'd4,
    FN_LOOKUP      = 3'd5,
    FN_INIT        = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ROW_NOP,
    ROW_ADD,
    ROW_DROP,
    ROW_CLEAR,
    ROW_AGE
  } row_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_DONE
  } state_t;

  typedef struct packed {
    row_op_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [TMO_W-1:0]    tmo;
    logic [SLOT_W-1:0]   idx;
  } row_cmd_t;

  typedef struct packed {
    logic                found;
    logic [CNT_W-1:0]    count;
    logic                expire;
  } row_stat_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic dec;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/pata_cell.sv
// ----------------------------------------------------------------------------
// pata_cell
// One list entry: address and timeout, loaded, aged or taken from the
// neighbor above when the list compacts.
// ----------------------------------------------------------------------------
`default_nettype none

module pata_cell (
  input  logic                          clk,
  input  pata_pkg::cell_ctl_t           ctl,
  input  logic [pata_pkg::ADDR_W-1:0]   load_addr,
  input  logic [pata_pkg::TMO_W-1:0]    load_tmo,
  input  logic [pata_pkg::ADDR_W-1:0]   up_addr,
  input  logic [pata_pkg::TMO_W-1:0]    up_tmo,
  output logic [pata_pkg::ADDR_W-1:0]   addr,
  output logic [pata_pkg::TMO_W-1:0]    tmo
);
  import pata_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr <= load_addr;
      tmo  <= load_tmo;
    end else if (ctl.shift) begin
      addr <= up_addr;
      tmo  <= up_tmo;
    end else if (ctl.dec) begin
      tmo <= tmo - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/pata_row.sv
// ----------------------------------------------------------------------------
// pata_row
// One track: a chain of entry cells plus the track's fill count. Search,
// append, reload, delete with compaction, clear and one aging step per command.
// ----------------------------------------------------------------------------
`default_nettype none

module pata_row #(
  parameter int ENTRIES = pata_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pata_pkg::row_cmd_t  cmd,
  output pata_pkg::row_stat_t stat
);
  import pata_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [ADDR_W-1:0] addr_q  [ENTRIES];
  logic [TMO_W-1:0]  tmo_q   [ENTRIES];
  logic [ADDR_W-1:0] up_addr [ENTRIES];
  logic [TMO_W-1:0]  up_tmo  [ENTRIES];
  cell_ctl_t         ctl     [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic              age_live;
  logic              age_expire;

  // search over live entries, lowest slot wins
  always_comb begin
    slot       = '0;
    age_expire = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < count) && (addr_q[i] == cmd.addr);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) slot = SLOT_W'(i);
    end
    found    = |match;
    age_live = CNT_W'(cmd.idx) < count;
    for (int i = 0; i < ENTRIES; i++) begin
      if (SLOT_W'(i) == cmd.idx) age_expire = (tmo_q[i] <= 8'd1);
    end
  end

  always_comb begin
    count_next = count;
    for (int i = 0; i < ENTRIES; i++) ctl[i] = '0;
    case (cmd.op)
      ROW_ADD: begin
        if (found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (SLOT_W'(i) == slot) ctl[i].load = 1'b1;
          end
        end else if (count < FULL_CNT) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (CNT_W'(i) == count) ctl[i].load = 1'b1;
          end
          count_next = count + 1'b1;
        end
      end
      ROW_DROP: begin
        if (found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (SLOT_W'(i) >= slot) ctl[i].shift = 1'b1;
          end
          count_next = count - 1'b1;
        end
      end
      ROW_CLEAR: begin
        count_next = '0;
      end
      ROW_AGE: begin
        if (age_live) begin
          if (age_expire) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (SLOT_W'(i) >= cmd.idx) ctl[i].shift = 1'b1;
            end
            count_next = count - 1'b1;
          end else begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (SLOT_W'(i) == cmd.idx) ctl[i].dec = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    // top cell has no upper neighbor, its content past the count is dead
    if (i == ENTRIES - 1) begin : g_top
      assign up_addr[i] = addr_q[i];
      assign up_tmo[i]  = tmo_q[i];
    end else begin : g_mid
      assign up_addr[i] = addr_q[i+1];
      assign up_tmo[i]  = tmo_q[i+1];
    end

    pata_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .load_addr (cmd.addr),
      .load_tmo  (cmd.tmo),
      .up_addr   (up_addr[i]),
      .up_tmo    (up_tmo[i]),
      .addr      (addr_q[i]),
      .tmo       (tmo_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.found  = found;
  assign stat.count  = count;
  assign stat.expire = age_live && age_expire;

endmodule

`default_nettype wire

FILE: design/per_track_address_aging_table_unit.sv
// ----------------------------------------------------------------------------
// per_track_address_aging_table_unit
// Per-track ordered address lists with per-entry timeouts, add, remove,
// aging, clear and lookup, and a sticky change flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   s_tuser func, s_tdata track, address
//  m_*       out        m_tvalid / m_tready   m_tdata status .. changed_flag
//  cfg_*     in         cfg_valid / cfg_ready cfg_data timeout_reload
//
//  result valid and s_tready return together once the beat has passed S_EXEC and S_DONE;
//  a tick inserts the S_TICK aging walk over every slot, one slot per cycle.
//  one beat is in work at a time; the output register lets the next beat in
//  while a result waits on m_tready.
//  rst is synchronous and clears all fill counts, the change flag and the result
//  valid, and sets reload to TMO_RESET; entry contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module per_track_address_aging_table_unit #(
  parameter int TRACK_COUNT       = pata_pkg::TRACK_COUNT_DEF,
  parameter int ENTRIES_PER_TRACK = pata_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // track[2:0], address[18:3], zero[23:19]
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], found[2], entry_count[6:3],
                                 // list_full[7], changed_flag[8], zero[15:9]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import pata_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(ENTRIES_PER_TRACK - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(ENTRIES_PER_TRACK);

  state_t            state;
  state_t            state_next;
  func_t             op;
  logic [TRK_W-1:0]  trk;
  logic [ADDR_W-1:0] adr;
  logic [TMO_W-1:0]  reload;
  logic              changed;
  logic              changed_next;
  logic              found_q;
  logic              found_next;
  status_t           status_q;
  status_t           status_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  row_cmd_t          cmd  [TRACK_COUNT];
  row_stat_t         stat [TRACK_COUNT];
  logic [TRACK_COUNT-1:0] row_sel;
  row_stat_t         sel_stat;
  logic              trk_ok;
  logic              any_count;
  logic              any_expire;
  logic              sel_full;
  logic              out_load;
  logic              out_valid;
  logic [15:0]       out_data;

  assign trk_ok = 32'(trk) < TRACK_COUNT;

  always_comb begin
    sel_stat   = '0;
    any_count  = 1'b0;
    any_expire = 1'b0;
    for (int r = 0; r < TRACK_COUNT; r++) begin
      row_sel[r] = trk_ok && (32'(trk) == r);
      if (row_sel[r]) sel_stat = stat[r];
      any_count  = any_count || (stat[r].count != '0);
      any_expire = any_expire || stat[r].expire;
    end
  end

  assign sel_full = sel_stat.count >= FULL_CNT;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    changed_next = changed;
    found_next   = found_q;
    status_next  = status_q;
    out_load     = 1'b0;
    for (int r = 0; r < TRACK_COUNT; r++) begin
      cmd[r].op   = ROW_NOP;
      cmd[r].addr = adr;
      cmd[r].tmo  = reload;
      cmd[r].idx  = idx;
    end
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        // rows still show the state before the operation here
        found_next  = sel_stat.found;
        status_next = ST_OK;
        state_next  = S_DONE;
        case (op)
          FN_TICK: begin
            idx_next   = LAST_IDX;
            state_next = S_TICK;
          end
          FN_ADD: begin
            if (trk_ok) begin
              for (int r = 0; r < TRACK_COUNT; r++) begin
                if (row_sel[r]) cmd[r].op = ROW_ADD;
              end
              if (!sel_stat.found) begin
                if (sel_full) status_next = ST_FULL;
                else changed_next = 1'b1;
              end
            end
          end
          FN_REMOVE: begin
            if (trk_ok) begin
              for (int r = 0; r < TRACK_COUNT; r++) begin
                if (row_sel[r]) cmd[r].op = ROW_DROP;
              end
              if (sel_stat.found) changed_next = 1'b1;
              else status_next = ST_NOT_FOUND;
            end
          end
          FN_CLEAR_TRACK: begin
            if (trk_ok) begin
              for (int r = 0; r < TRACK_COUNT; r++) begin
                if (row_sel[r]) cmd[r].op = ROW_CLEAR;
              end
              if (sel_stat.count != '0) changed_next = 1'b1;
            end
          end
          FN_CLEAR_ALL: begin
            for (int r = 0; r < TRACK_COUNT; r++) cmd[r].op = ROW_CLEAR;
            if (any_count) changed_next = 1'b1;
          end
          FN_LOOKUP: begin
            if (trk_ok && !sel_stat.found) status_next = ST_NOT_FOUND;
          end
          FN_INIT: begin
            for (int r = 0; r < TRACK_COUNT; r++) cmd[r].op = ROW_CLEAR;
            changed_next = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_TICK: begin
        // walk slots from the top down in every row at once
        for (int r = 0; r < TRACK_COUNT; r++) cmd[r].op = ROW_AGE;
        if (any_expire) changed_next = 1'b1;
        if (idx == '0) state_next = S_DONE;
        else idx_next = idx - 1'b1;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar r = 0; r < TRACK_COUNT; r++) begin : g_row
    pata_row #(
      .ENTRIES (ENTRIES_PER_TRACK)
    ) u_row (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[r]),
      .stat (stat[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      changed   <= 1'b0;
      out_valid <= 1'b0;
      reload    <= TMO_RESET;
    end else begin
      state   <= state_next;
      changed <= changed_next;
      if (cfg_valid) reload <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= func_t'(s_tuser);
      trk <= s_tdata[2:0];
      adr <= s_tdata[18:3];
    end
    idx      <= idx_next;
    found_q  <= found_next;
    status_q <= status_next;
    if (out_load) begin
      out_data <= {7'b0, changed, sel_full, sel_stat.count[3:0], found_q, status_q};
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

endmodule

`default_nettype wire

FILE: design/pata_checker.sv
// ----------------------------------------------------------------------------
// pata_checker
// Port-level checks on result codes and beat sequencing, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pata_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import pata_pkg::*;

  // a rejected add only happens on a full track without the address
  `CHK_IMP(a_full_reject, m_tvalid && (m_tdata[1:0] == ST_FULL), m_tdata[7] && !m_tdata[2], "reject without full list")
  // not found never comes with the found bit
  `CHK_IMP(a_not_found, m_tvalid && (m_tdata[1:0] == ST_NOT_FOUND), !m_tdata[2], "not found but found set")
  // no status code beyond the defined ones
  `CHK_IMP(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3, "undefined status code")
  // one beat in work at a time
  `CHK_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
  // a stalled result holds
  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind per_track_address_aging_table_unit pata_checker u_chk (.*);

`default_nettype wire
